/* hw/rtl/rgbyuv_pkg.sv */
// Shared constants, register indexes and color math for the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

package rgbyuv_pkg;

   localparam int MAX_WIDTH_DEFAULT = 4096;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int CSR_DATA_W        = 13;
   localparam int ROW_W             = 12;
   localparam int GEOM_W            = 14;

   localparam logic [CSR_DATA_W-1:0] RESET_LINE_WIDTH   = 13'd640;
   localparam logic [CSR_DATA_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

   typedef enum logic [1:0] {
      CSR_LINE_WIDTH    = 2'd0,
      CSR_FRAME_HEIGHT  = 2'd1,
      CSR_CHANNEL_ORDER = 2'd2,
      CSR_CHROMA_MODE   = 2'd3
   } csr_index_type;

   // Round down to even, then saturate into [2, hi rounded down to even].
   function automatic logic [GEOM_W-1:0] clamp_even(input logic [CSR_DATA_W-1:0] v,
                                                     input logic [GEOM_W-1:0] hi);
      logic [GEOM_W-1:0] e;
      logic [GEOM_W-1:0] h;
      e = {1'b0, v[CSR_DATA_W-1:1], 1'b0};
      h = {hi[GEOM_W-1:1], 1'b0};
      if (e < 14'd2) begin
         e = 14'd2;
      end
      if (e > hi) begin
         e = h;
      end
      return e;
   endfunction

   function automatic logic [7:0] luma_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [15:0] s;
      s = 16'(16'(b) * 16'd25) + 16'(16'(g) * 16'd129) + 16'(16'(r) * 16'd66);
      return s[15:8] + 8'd16;
   endfunction

   // floor((112*B - 38*R - 74*G) / 256) + 128, on a biased non-negative sum
   function automatic logic [7:0] cb_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
      logic [15:0] p;
      logic [15:0] n;
      logic [15:0] s;
      p = 16'd32768 + 16'(16'(b) * 16'd112);
      n = 16'(16'(r) * 16'd38) + 16'(16'(g) * 16'd74);
      s = p - n;
      return s[15:8];
   endfunction

   // floor((112*R - 94*G - 18*B) / 256) + 128
   function automatic logic [7:0] cr_of(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
      logic [15:0] p;
      logic [15:0] n;
      logic [15:0] s;
      p = 16'd32768 + 16'(16'(r) * 16'd112);
      n = 16'(16'(g) * 16'd94) + 16'(16'(b) * 16'd18);
      s = p - n;
      return s[15:8];
   endfunction

endpackage

/* hw/rtl/rgbyuv_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module rgbyuv_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/rgb_to_yuv420_converter_unit.sv */
// RGB to YUV 4:2:0 (BT.601 studio swing) converter, top level.
// A result passes through stage 1, stage 2 and the output register after its pixel beat is accepted.
// Throughput: one pixel per cycle; three stages (line store read, chroma
// component select, multiply) each hold one beat and stall only on rsp_ready.
// Reset (synchronous, active high) empties the pipeline, clears the counters and
// loads the default geometry; the pair-sum line store is not cleared.
`timescale 1ns / 1ps

module rgb_to_yuv420_converter_unit #(
   parameter int MAX_WIDTH = rgbyuv_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_component_first,
   input  logic [7:0]                        req_component_second,
   input  logic [7:0]                        req_component_third,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_luma,
   output logic                              rsp_chroma_valid,
   output logic [7:0]                        rsp_chroma_blue,
   output logic [7:0]                        rsp_chroma_red,
   output logic                              rsp_frame_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [rgbyuv_pkg::CSR_DATA_W-1:0] csr_data
);

   import rgbyuv_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = 27;
   localparam logic [GEOM_W-1:0] WIDTH_HI  = GEOM_W'(MAX_WIDTH);
   localparam logic [GEOM_W-1:0] HEIGHT_HI = GEOM_W'(HEIGHT_LIMIT);

   // configuration
   logic [GEOM_W-1:0] width_ff, width_in;
   logic [GEOM_W-1:0] height_ff, height_in;
   logic              order_ff, order_in;
   logic              mode_ff, mode_in;
   logic              csr_fire;

   // position and pair state
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [23:0]      left_ff, left_in;

   // pipeline stage 1
   logic       s1_v_ff, s1_v_in;
   logic [7:0] s1_r_ff, s1_g_ff, s1_b_ff;
   logic [8:0] s1_sr_ff, s1_sg_ff, s1_sb_ff;
   logic       s1_cv_ff, s1_avg_ff, s1_fend_ff;

   // pipeline stage 2
   logic       s2_v_ff, s2_v_in;
   logic [7:0] s2_r_ff, s2_g_ff, s2_b_ff;
   logic [7:0] s2_cr_ff, s2_cg_ff, s2_cb_ff;
   logic       s2_cv_ff, s2_fend_ff;

   // output register
   logic       out_v_ff, out_v_in;
   logic [7:0] out_luma_ff, out_blue_ff, out_red_ff;
   logic       out_cv_ff, out_fend_ff;

   logic       out_adv, s2_adv, s1_adv, accept;
   logic [7:0] pix_r, pix_g, pix_b;
   logic [8:0] sum_r, sum_g, sum_b;
   logic       col_odd, row_odd, last_col, last_row;
   logic       cv_point, cv_avg, mem_wr, mem_rd;
   logic [AW-1:0] mem_addr;
   logic [SW-1:0] mem_wdata, mem_rdata;
   logic [9:0] avg_r, avg_g, avg_b;
   logic [7:0] sel_r, sel_g, sel_b;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   assign out_adv   = ~out_v_ff | rsp_ready;
   assign s2_adv    = ~s2_v_ff | out_adv;
   assign s1_adv    = ~s1_v_ff | s2_adv;
   assign req_ready = s1_adv;
   assign accept    = req_valid & req_ready;

   assign pix_r = order_ff ? req_component_third : req_component_first;
   assign pix_g = req_component_second;
   assign pix_b = order_ff ? req_component_first : req_component_third;

   assign sum_r = {1'b0, left_ff[7:0]} + {1'b0, pix_r};
   assign sum_g = {1'b0, left_ff[15:8]} + {1'b0, pix_g};
   assign sum_b = {1'b0, left_ff[23:16]} + {1'b0, pix_b};

   assign col_odd  = col_ff[0];
   assign row_odd  = row_ff[0];
   assign last_col = (GEOM_W'(col_ff) + GEOM_W'(1)) >= width_ff;
   assign last_row = (GEOM_W'(row_ff) + GEOM_W'(1)) >= height_ff;
   assign cv_point = ~col_odd & ~row_odd & ~mode_ff;
   assign cv_avg   = col_odd & row_odd & mode_ff;

   assign mem_addr  = col_ff[AW:1];
   assign mem_wdata = {sum_b, sum_g, sum_r};
   assign mem_wr    = accept & col_odd & ~row_odd;
   assign mem_rd    = accept & col_odd & row_odd;

   rgbyuv_ram #(
      .WIDTH (SW),
      .DEPTH (DEPTH)
   ) u_pair_line (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_en   (mem_rd),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   // 2x2 sum from this row's pair and the stored even-row pair
   assign avg_r = {1'b0, s1_sr_ff} + {1'b0, mem_rdata[8:0]};
   assign avg_g = {1'b0, s1_sg_ff} + {1'b0, mem_rdata[17:9]};
   assign avg_b = {1'b0, s1_sb_ff} + {1'b0, mem_rdata[26:18]};
   assign sel_r = s1_avg_ff ? avg_r[9:2] : s1_r_ff;
   assign sel_g = s1_avg_ff ? avg_g[9:2] : s1_g_ff;
   assign sel_b = s1_avg_ff ? avg_b[9:2] : s1_b_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      order_in  = order_ff;
      mode_in   = mode_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      left_in   = left_ff;
      if (csr_fire) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_WIDTH: begin
               width_in = clamp_even(csr_data, WIDTH_HI);
               col_in   = '0;
               row_in   = '0;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = clamp_even(csr_data, HEIGHT_HI);
               col_in    = '0;
               row_in    = '0;
            end
            CSR_CHANNEL_ORDER: order_in = csr_data[0];
            CSR_CHROMA_MODE:   mode_in  = csr_data[0];
         endcase
      end else if (accept) begin
         if (~col_odd) begin
            left_in = {pix_b, pix_g, pix_r};
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign s1_v_in  = accept | (s1_v_ff & ~s2_adv);
   assign s2_v_in  = (s1_v_ff & s2_adv) | (s2_v_ff & ~out_adv);
   assign out_v_in = (s2_v_ff & out_adv) | (out_v_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= clamp_even(RESET_LINE_WIDTH, WIDTH_HI);
         height_ff <= clamp_even(RESET_FRAME_HEIGHT, HEIGHT_HI);
         order_ff  <= 1'b0;
         mode_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         s1_v_ff   <= 1'b0;
         s2_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         order_ff  <= order_in;
         mode_ff   <= mode_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         s1_v_ff   <= s1_v_in;
         s2_v_ff   <= s2_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_r_ff    <= pix_r;
         s1_g_ff    <= pix_g;
         s1_b_ff    <= pix_b;
         s1_sr_ff   <= sum_r;
         s1_sg_ff   <= sum_g;
         s1_sb_ff   <= sum_b;
         s1_cv_ff   <= cv_point | cv_avg;
         s1_avg_ff  <= cv_avg;
         s1_fend_ff <= last_col & last_row;
      end
      if (s1_v_ff & s2_adv) begin
         s2_r_ff    <= s1_r_ff;
         s2_g_ff    <= s1_g_ff;
         s2_b_ff    <= s1_b_ff;
         s2_cr_ff   <= sel_r;
         s2_cg_ff   <= sel_g;
         s2_cb_ff   <= sel_b;
         s2_cv_ff   <= s1_cv_ff;
         s2_fend_ff <= s1_fend_ff;
      end
      if (s2_v_ff & out_adv) begin
         out_luma_ff <= luma_of(s2_r_ff, s2_g_ff, s2_b_ff);
         out_blue_ff <= s2_cv_ff ? cb_of(s2_cr_ff, s2_cg_ff, s2_cb_ff) : 8'd0;
         out_red_ff  <= s2_cv_ff ? cr_of(s2_cr_ff, s2_cg_ff, s2_cb_ff) : 8'd0;
         out_cv_ff   <= s2_cv_ff;
         out_fend_ff <= s2_fend_ff;
      end
   end

   assign rsp_valid        = out_v_ff;
   assign rsp_luma         = out_luma_ff;
   assign rsp_chroma_valid = out_cv_ff;
   assign rsp_chroma_blue  = out_blue_ff;
   assign rsp_chroma_red   = out_red_ff;
   assign rsp_frame_end    = out_fend_ff;

   a_no_chroma_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chroma_valid) |-> (rsp_chroma_blue == 8'd0 && rsp_chroma_red == 8'd0))
      else $error("chroma bytes nonzero on a beat without chroma");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && !csr_fire && last_col && last_row) |=> (col_ff == '0 && row_ff == '0))
      else $error("counters did not wrap after the last pixel of the frame");

   a_line_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr && mem_rd))
      else $error("line store written and read in the same cycle");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s2_adv) |=> s1_v_ff)
      else $error("stage 1 dropped a beat while stalled");

endmodule

/* test/tb.sv */
// Self-checking testbench for the RGB to YUV 4:2:0 converter: directed and random pixels.
`timescale 1ns / 1ps

module tb;
   import rgbyuv_pkg::*;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
      logic       frame_end;
   } yuv_beat_type;

   localparam int PAIR_SLOTS = MAX_WIDTH_DEFAULT / 2;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_component_first = '0;
   logic [7:0]            req_component_second = '0;
   logic [7:0]            req_component_third = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_luma;
   logic                  rsp_chroma_valid;
   logic [7:0]            rsp_chroma_blue;
   logic [7:0]            rsp_chroma_red;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int beats_seen = 0;
   yuv_beat_type yuv_expected[$];

   // predictor state
   logic [CSR_DATA_W-1:0] width_reg = RESET_LINE_WIDTH;
   logic [CSR_DATA_W-1:0] height_reg = RESET_FRAME_HEIGHT;
   logic                  order_reg = 1'b0;
   logic                  mode_reg = 1'b0;
   int                    column = 0;
   int                    row = 0;
   logic [7:0]            left_r = '0;
   logic [7:0]            left_g = '0;
   logic [7:0]            left_b = '0;
   logic [26:0]           pair_sums [PAIR_SLOTS];

   rgb_to_yuv420_converter_unit dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic int even_clamp(input int v, input int hi);
      int e;
      e = v & ~1;
      if (e < 2) e = 2;
      if (e > hi) e = hi & ~1;
      return e;
   endfunction

   function automatic logic [7:0] chroma_byte(input int kr, input int kg, input int kb,
                                              input int r, input int g, input int b);
      int s;
      s = kr * r + kg * g + kb * b + 32768;
      return 8'(s >> 8);
   endfunction

   task automatic predict_pixel(input logic [7:0] first, input logic [7:0] second,
                                input logic [7:0] third);
      int r, g, b, w, h, idx, sr, sg, sb, cr_r, cr_g, cr_b;
      yuv_beat_type beat;
      r = order_reg ? third : first;
      g = second;
      b = order_reg ? first : third;
      w = even_clamp(width_reg, MAX_WIDTH_DEFAULT);
      h = even_clamp(height_reg, HEIGHT_LIMIT);
      idx = (column >> 1) % PAIR_SLOTS;
      cr_r = 0;
      cr_g = 0;
      cr_b = 0;
      beat = '0;
      beat.luma = 8'(((25 * b + 129 * g + 66 * r) >> 8) + 16);
      if (column % 2 == 0) begin
         left_r = 8'(r);
         left_g = 8'(g);
         left_b = 8'(b);
         if (!mode_reg && row % 2 == 0) begin
            beat.chroma_valid = 1'b1;
            cr_r = r;
            cr_g = g;
            cr_b = b;
         end
      end else begin
         sr = left_r + r;
         sg = left_g + g;
         sb = left_b + b;
         if (row % 2 == 0) begin
            pair_sums[idx] = {9'(sb), 9'(sg), 9'(sr)};
         end else if (mode_reg) begin
            beat.chroma_valid = 1'b1;
            cr_r = (sr + int'(pair_sums[idx][8:0])) >> 2;
            cr_g = (sg + int'(pair_sums[idx][17:9])) >> 2;
            cr_b = (sb + int'(pair_sums[idx][26:18])) >> 2;
         end
      end
      if (beat.chroma_valid) begin
         beat.chroma_blue = chroma_byte(-38, -74, 112, cr_r, cr_g, cr_b);
         beat.chroma_red  = chroma_byte(112, -94, -18, cr_r, cr_g, cr_b);
      end
      if (column + 1 >= w) begin
         column = 0;
         if (row + 1 >= h) begin
            row = 0;
            beat.frame_end = 1'b1;
         end else begin
            row = row + 1;
         end
      end else begin
         column = column + 1;
      end
      yuv_expected.push_back(beat);
   endtask

   task automatic write_csr(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_LINE_WIDTH: begin
            width_reg = data;
            column = 0;
            row = 0;
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = data;
            column = 0;
            row = 0;
         end
         CSR_CHANNEL_ORDER: order_reg = data[0];
         CSR_CHROMA_MODE: mode_reg = data[0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_pixel(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] third);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_component_first  <= first;
      req_component_second <= second;
      req_component_third  <= third;
      do @(posedge clock); while (!req_ready);
      predict_pixel(first, second, third);
   endtask

   function automatic logic [7:0] pick_component();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_geometry(input int hi);
      case ($urandom_range(9))
         0: return CSR_DATA_W'($urandom);
         1: return CSR_DATA_W'($urandom_range(3));
         default: return CSR_DATA_W'($urandom_range(2, hi));
      endcase
   endfunction

   task automatic send_random_pixel();
      send_pixel(pick_component(), pick_component(), pick_component());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (yuv_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      settle();
   endtask

   // odd geometry values round down to a 2x2 frame
   task automatic test_color_extremes();
      write_csr(CSR_LINE_WIDTH, 13'd3);
      write_csr(CSR_FRAME_HEIGHT, 13'd1);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      settle();
      write_csr(CSR_CHROMA_MODE, 13'd1);
      write_csr(CSR_FRAME_HEIGHT, 13'd0);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'hFE);
      settle();
      write_csr(CSR_CHANNEL_ORDER, 13'd1);
      write_csr(CSR_CHROMA_MODE, 13'd0);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      settle();
   endtask

   // restart mid-frame, then average over a row stored in point mode
   task automatic test_restart_and_mode_switch();
      write_csr(CSR_CHANNEL_ORDER, 13'd0);
      write_csr(CSR_LINE_WIDTH, 13'd4);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      write_csr(CSR_CHROMA_MODE, 13'd1);
      repeat (3) send_random_pixel();
      settle();
      write_csr(CSR_LINE_WIDTH, 13'd4);
      write_csr(CSR_CHROMA_MODE, 13'd0);
      repeat (4) send_random_pixel();
      settle();
      write_csr(CSR_CHROMA_MODE, 13'd1);
      repeat (4) send_random_pixel();
      settle();
   endtask

   task automatic test_widest_line();
      write_csr(CSR_LINE_WIDTH, 13'h1FFF);
      write_csr(CSR_FRAME_HEIGHT, 13'd2);
      write_csr(CSR_CHROMA_MODE, 13'd1);
      repeat (128) send_random_pixel();
      settle();
   endtask

   task automatic test_tallest_frame();
      write_csr(CSR_LINE_WIDTH, 13'd0);
      write_csr(CSR_FRAME_HEIGHT, 13'h1FFF);
      write_csr(CSR_CHANNEL_ORDER, CSR_DATA_W'($urandom));
      repeat (128) send_random_pixel();
      settle();
   endtask

   task automatic test_random_traffic();
      int idle_plan [4] = '{0, 55, 0, 28};
      int stall_plan [4] = '{0, 0, 55, 28};
      int sent;
      int count;
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         sent = 0;
         while (sent < 175) begin
            settle();
            if (sent == 0 || $urandom_range(1)) write_csr(CSR_LINE_WIDTH, pick_geometry(16));
            if (sent == 0 || $urandom_range(1)) write_csr(CSR_FRAME_HEIGHT, pick_geometry(6));
            if ($urandom_range(1)) write_csr(CSR_CHANNEL_ORDER, CSR_DATA_W'($urandom));
            if ($urandom_range(1)) write_csr(CSR_CHROMA_MODE, CSR_DATA_W'($urandom));
            count = $urandom_range(10, 70);
            repeat (count) send_random_pixel();
            sent += count;
         end
      end
      settle();
   endtask

   always @(posedge clock) begin : check_beats
      yuv_beat_type want;
      yuv_beat_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_luma, rsp_chroma_valid, rsp_chroma_blue, rsp_chroma_red, rsp_frame_end};
         if (yuv_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("beat %0d arrived with none pending", beats_seen);
         end else begin
            want = yuv_expected.pop_front();
            if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid ||
                got.chroma_blue !== want.chroma_blue || got.chroma_red !== want.chroma_red ||
                got.frame_end !== want.frame_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"beat %0d: expected Y %0d cv %b Cb %0d Cr %0d end %b, ",
                            "got Y %0d cv %b Cb %0d Cr %0d end %b"},
                           beats_seen, want.luma, want.chroma_valid, want.chroma_blue,
                           want.chroma_red, want.frame_end, got.luma, got.chroma_valid,
                           got.chroma_blue, got.chroma_red, got.frame_end);
            end
         end
         beats_seen++;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_color_extremes();
      test_restart_and_mode_switch();
      test_widest_line();
      test_tallest_frame();
      test_random_traffic();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && yuv_expected.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
